// ===== hdl/msc_stream_demultiplexer_top_defines.svh =====
// assertion macros used by the checker file
`ifndef MSC_STREAM_DEMULTIPLEXER_TOP_DEFINES_SVH
`define MSC_STREAM_DEMULTIPLEXER_TOP_DEFINES_SVH

// next-cycle implication, disabled while reset is high
`define MSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("msc stream demux check failed");

// next-cycle implication that also covers reset itself
`define MSC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("msc stream demux check failed");

`endif

// ===== hdl/msc_pkg.sv =====
`timescale 1ns / 1ps

package msc_pkg;

   // stream count default and fixed field widths
   localparam int NUM_STREAMS_DEF = 4;
   localparam int POS_W           = 17;
   localparam int IDX_W           = 18;
   localparam int LEN_W           = 19;
   localparam int SUM_W           = 21;
   localparam int OFF_W           = 23;
   localparam int END_W           = 24;
   localparam int ID_W            = 2;
   localparam int BYTES_W         = 16;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_BITS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PART_A_BYTES    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PART_B_BYTES    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_MASK     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HIER_MODE       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HIER_FRAME_BITS = 3'd5;

   // cycles the window pipeline needs after a write or reset
   localparam int SETTLE     = 2;
   localparam int SETTLE_W   = 2;

   // queue between front and back
   localparam int FIFO_DEPTH = 8;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 2);

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   typedef struct packed {
      logic data_bit;
      logic frame_start;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]  stream_id;
      logic [POS_W-1:0] stream_pos;
      logic             out_bit;
      logic             block_end;
      logic             last_result;
   } rsp_type;

   // window of one stream, already cleared when impossible
   typedef struct packed {
      logic [POS_W-1:0] off_a;
      logic [POS_W-1:0] end_a;
      logic [POS_W-1:0] off_b;
      logic [POS_W-1:0] end_b;
      logic [IDX_W-1:0] base_b;
      logic [IDX_W-1:0] last_idx;
   } win_type;

   // per stream part of a queued word
   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] pos;
      logic             last;
   } lane_type;

endpackage

// ===== hdl/msc_stream_demultiplexer_top.sv =====
`timescale 1ns / 1ps
// path: an accepted bit passes the input stage, the match stage and the queue head before its first result shows
// throughput: one input bit per cycle while full is low; the back sequencer issues one result per cycle
//   while pop is high, so a bit that lands in several streams holds the back end until all its results are taken
// reset: synchronous, active high; clears registers, position and queue, and input is held
//   off (full) after reset and after each register write while windows recompute
module msc_stream_demultiplexer_top #(
   parameter int NUM_STREAMS = msc_pkg::NUM_STREAMS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  msc_pkg::req_type                req_word,
   output logic                            empty,
   input  logic                            pop,
   output msc_pkg::rsp_type                rsp_word,
   input  logic                            csr_wr_en,
   input  logic [msc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [msc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import msc_pkg::*;

   localparam int ENTRY_W = 1 + NUM_STREAMS * $bits(lane_type);

   logic               busy;
   win_type            win [NUM_STREAMS];
   logic               fifo_wr;
   logic [ENTRY_W-1:0] fifo_wdata;
   logic               fifo_rd;
   logic               head_valid;
   logic [ENTRY_W-1:0] head_data;
   logic [LEVEL_W-1:0] fifo_level;

   // registers and stream windows
   msc_cfg #(
      .NUM_STREAMS (NUM_STREAMS)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .busy      (busy),
      .win       (win)
   );

   // position tracking and classification
   msc_front #(
      .NUM_STREAMS (NUM_STREAMS),
      .ENTRY_W     (ENTRY_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_word   (req_word),
      .busy       (busy),
      .win        (win),
      .fifo_level (fifo_level),
      .fifo_wr    (fifo_wr),
      .fifo_wdata (fifo_wdata)
   );

   // queue between classification and result issue
   msc_fifo #(
      .WIDTH (ENTRY_W)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .wr         (fifo_wr),
      .wr_data    (fifo_wdata),
      .rd         (fifo_rd),
      .head_valid (head_valid),
      .head_data  (head_data),
      .level      (fifo_level)
   );

   // one result per cycle, while the receiver pops, out of each queued word
   msc_back #(
      .NUM_STREAMS (NUM_STREAMS),
      .ENTRY_W     (ENTRY_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .fifo_rd    (fifo_rd),
      .empty      (empty),
      .pop        (pop),
      .rsp_word   (rsp_word)
   );

endmodule

// ===== hdl/msc_cfg.sv =====
`timescale 1ns / 1ps

module msc_cfg #(
   parameter int NUM_STREAMS = msc_pkg::NUM_STREAMS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [msc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [msc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                            busy,
   output msc_pkg::win_type                win [NUM_STREAMS]
);
   import msc_pkg::*;

   logic [POS_W-1:0]      frame_bits_ff;
   logic [CSR_DATA_W-1:0] part_a_ff;
   logic [CSR_DATA_W-1:0] part_b_ff;
   logic [3:0]            active_ff;
   logic                  hier_ff;
   logic [POS_W-1:0]      hier_bits_ff;
   logic [SETTLE_W-1:0]   settle_ff;

   // register writes, settle count holds the input off while windows recompute
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_bits_ff <= '0;
         part_a_ff     <= '0;
         part_b_ff     <= '0;
         active_ff     <= '0;
         hier_ff       <= 1'b0;
         hier_bits_ff  <= '0;
         settle_ff     <= SETTLE_W'(SETTLE);
      end else begin
         if (csr_wr_en) begin
            settle_ff <= SETTLE_W'(SETTLE);
            case (csr_index)
               CSR_FRAME_BITS:      frame_bits_ff <= csr_wdata[POS_W-1:0];
               CSR_PART_A_BYTES:    part_a_ff     <= csr_wdata;
               CSR_PART_B_BYTES:    part_b_ff     <= csr_wdata;
               CSR_ACTIVE_MASK:     active_ff     <= csr_wdata[3:0];
               CSR_HIER_MODE:       hier_ff       <= csr_wdata[0];
               CSR_HIER_FRAME_BITS: hier_bits_ff  <= csr_wdata[POS_W-1:0];
               default: ;
            endcase
         end else if (settle_ff != '0) begin
            settle_ff <= settle_ff - 1'b1;
         end
      end
   end

   assign busy = (settle_ff != '0);

   // first step: lengths in bits and running sums over active streams
   logic [LEN_W-1:0] la_in     [NUM_STREAMS];
   logic [LEN_W-1:0] lb_in     [NUM_STREAMS];
   logic [SUM_W-1:0] pre_a_in  [NUM_STREAMS];
   logic [SUM_W-1:0] pre_b_in  [NUM_STREAMS];
   logic [SUM_W-1:0] pre_bx_in [NUM_STREAMS];
   logic [SUM_W-1:0] tot_a_in;

   always_comb begin : sums
      logic [SUM_W-1:0] acc_a;
      logic [SUM_W-1:0] acc_b;
      logic [SUM_W-1:0] acc_bx;
      acc_a  = '0;
      acc_b  = '0;
      acc_bx = '0;
      for (int s = 0; s < NUM_STREAMS; s++) begin
         la_in[s]     = {part_a_ff[BYTES_W*s +: BYTES_W], 3'b000};
         lb_in[s]     = {part_b_ff[BYTES_W*s +: BYTES_W], 3'b000};
         pre_a_in[s]  = acc_a;
         pre_b_in[s]  = acc_b;
         pre_bx_in[s] = acc_bx;
         if (active_ff[s]) begin
            acc_a = acc_a + SUM_W'(la_in[s]);
            acc_b = acc_b + SUM_W'(lb_in[s]);
            // stream 0's part B sits at the frame start in hierarchical mode
            if (s != 0) begin
               acc_bx = acc_bx + SUM_W'(lb_in[s]);
            end
         end
      end
      tot_a_in = acc_a;
   end

   logic [LEN_W-1:0] la_ff     [NUM_STREAMS];
   logic [LEN_W-1:0] lb_ff     [NUM_STREAMS];
   logic [SUM_W-1:0] pre_a_ff  [NUM_STREAMS];
   logic [SUM_W-1:0] pre_b_ff  [NUM_STREAMS];
   logic [SUM_W-1:0] pre_bx_ff [NUM_STREAMS];
   logic [SUM_W-1:0] tot_a_ff;

   always_ff @(posedge clock) begin
      la_ff     <= la_in;
      lb_ff     <= lb_in;
      pre_a_ff  <= pre_a_in;
      pre_b_ff  <= pre_b_in;
      pre_bx_ff <= pre_bx_in;
      tot_a_ff  <= tot_a_in;
   end

   // second step: window offsets, with the hierarchical shift
   logic [OFF_W-1:0] oa_in [NUM_STREAMS];
   logic [OFF_W-1:0] ob_in [NUM_STREAMS];

   always_comb begin
      for (int s = 0; s < NUM_STREAMS; s++) begin
         oa_in[s] = OFF_W'(pre_a_ff[s]);
         ob_in[s] = OFF_W'(tot_a_ff) + OFF_W'(pre_b_ff[s]);
         if (hier_ff) begin
            if (s == 0) begin
               ob_in[s] = '0;
            end else begin
               oa_in[s] = OFF_W'(pre_a_ff[s]) + OFF_W'(hier_bits_ff);
               ob_in[s] = OFF_W'(tot_a_ff) + OFF_W'(pre_bx_ff[s]) + OFF_W'(hier_bits_ff);
            end
         end
      end
   end

   logic [OFF_W-1:0] oa_ff [NUM_STREAMS];
   logic [OFF_W-1:0] ob_ff [NUM_STREAMS];

   always_ff @(posedge clock) begin
      oa_ff <= oa_in;
      ob_ff <= ob_in;
   end

   // third step: window ends, frame check and the lookup constants
   win_type win_in [NUM_STREAMS];

   always_comb begin
      for (int s = 0; s < NUM_STREAMS; s++) begin : ends
         logic [END_W-1:0] ea;
         logic [END_W-1:0] eb;
         logic             ok;
         ea = END_W'(oa_ff[s]) + END_W'(la_ff[s]);
         eb = END_W'(ob_ff[s]) + END_W'(lb_ff[s]);
         ok = (ea <= END_W'(frame_bits_ff)) && (eb <= END_W'(frame_bits_ff));
         if (ok) begin
            win_in[s].off_a    = oa_ff[s][POS_W-1:0];
            win_in[s].end_a    = ea[POS_W-1:0];
            win_in[s].off_b    = ob_ff[s][POS_W-1:0];
            win_in[s].end_b    = eb[POS_W-1:0];
            win_in[s].base_b   = la_ff[s][IDX_W-1:0] - ob_ff[s][IDX_W-1:0];
            win_in[s].last_idx = la_ff[s][IDX_W-1:0] + lb_ff[s][IDX_W-1:0] - 1'b1;
         end else begin
            win_in[s] = '0;
         end
      end
   end

   win_type win_ff [NUM_STREAMS];

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign win = win_ff;

endmodule

// ===== hdl/msc_front.sv =====
`timescale 1ns / 1ps

module msc_front #(
   parameter int NUM_STREAMS = msc_pkg::NUM_STREAMS_DEF,
   parameter int ENTRY_W     = 1 + NUM_STREAMS * $bits(msc_pkg::lane_type)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  msc_pkg::req_type              req_word,
   input  logic                          busy,
   input  msc_pkg::win_type              win [NUM_STREAMS],
   input  logic [msc_pkg::LEVEL_W-1:0]   fifo_level,
   output logic                          fifo_wr,
   output logic [ENTRY_W-1:0]            fifo_wdata
);
   import msc_pkg::*;

   typedef struct packed {
      logic                         data_bit;
      lane_type [NUM_STREAMS-1:0]   lane;
   } entry_type;

   localparam logic [LEVEL_W:0] CAP = (LEVEL_W + 1)'(FIFO_DEPTH + 1);

   logic             v1_ff;
   logic             v2_ff;
   logic [POS_W-1:0] pos1_ff;
   logic             bit1_ff;
   logic [POS_W-1:0] fpos_ff;
   logic [POS_W-1:0] pos_in;
   logic [POS_W-1:0] fpos_in;
   logic [LEVEL_W:0] reserved;
   logic             accept;

   // every word in flight owns a queue slot, so the pipe never stalls
   assign reserved = (LEVEL_W + 1)'(fifo_level) + (LEVEL_W + 1)'(v1_ff)
                   + (LEVEL_W + 1)'(v2_ff);
   assign full     = busy || (reserved >= CAP);
   assign accept   = push && !full;

   // frame position, saturating at the top
   assign pos_in  = req_word.frame_start ? '0 : fpos_ff;
   assign fpos_in = (pos_in == POS_MAX) ? pos_in : pos_in + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fpos_ff <= '0;
         v1_ff   <= 1'b0;
      end else begin
         v1_ff <= accept;
         if (accept) begin
            fpos_ff <= fpos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pos1_ff <= pos_in;
         bit1_ff <= req_word.data_bit;
      end
   end

   // window match per stream, part A first
   logic             hit_in [NUM_STREAMS];
   logic [IDX_W-1:0] idx_in [NUM_STREAMS];

   always_comb begin
      for (int s = 0; s < NUM_STREAMS; s++) begin : match
         logic hit_a;
         logic hit_b;
         hit_a = (pos1_ff >= win[s].off_a) && (pos1_ff < win[s].end_a);
         hit_b = (pos1_ff >= win[s].off_b) && (pos1_ff < win[s].end_b);
         hit_in[s] = hit_a || hit_b;
         if (hit_a) begin
            idx_in[s] = {1'b0, pos1_ff - win[s].off_a};
         end else begin
            idx_in[s] = {1'b0, pos1_ff} + win[s].base_b;
         end
      end
   end

   logic             hit2_ff [NUM_STREAMS];
   logic [IDX_W-1:0] idx2_ff [NUM_STREAMS];
   logic             bit2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      hit2_ff <= hit_in;
      idx2_ff <= idx_in;
      bit2_ff <= bit1_ff;
   end

   // build the queued word, padding bits are dropped here
   entry_type entry;
   logic      any_hit;

   always_comb begin
      entry.data_bit = bit2_ff;
      any_hit        = 1'b0;
      for (int s = 0; s < NUM_STREAMS; s++) begin
         entry.lane[s].hit  = hit2_ff[s];
         entry.lane[s].pos  = idx2_ff[s][POS_W-1:0];
         entry.lane[s].last = (idx2_ff[s] == win[s].last_idx);
         any_hit            = any_hit | hit2_ff[s];
      end
   end

   assign fifo_wr    = v2_ff && any_hit;
   assign fifo_wdata = entry;

endmodule

// ===== hdl/msc_fifo.sv =====
`timescale 1ns / 1ps

module msc_fifo #(
   parameter int WIDTH = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr,
   input  logic [WIDTH-1:0]              wr_data,
   input  logic                          rd,
   output logic                          head_valid,
   output logic [WIDTH-1:0]              head_data,
   output logic [msc_pkg::LEVEL_W-1:0]   level
);
   import msc_pkg::*;

   logic [WIDTH-1:0] mem [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             head_valid_ff;
   logic [WIDTH-1:0] head_data_ff;

   logic head_from_mem;
   logic write_head;
   logic write_mem;
   logic head_valid_in;

   // head register sits in front of the memory so the oldest word is always shown
   assign head_from_mem = rd && (count_ff != '0);
   assign write_head    = wr && (!head_valid_ff || (rd && count_ff == '0));
   assign write_mem     = wr && !write_head;
   assign head_valid_in = write_head || head_from_mem || (head_valid_ff && !rd);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         head_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         if (write_mem) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (head_from_mem) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_W'(write_mem) - CNT_W'(head_from_mem);
      end
   end

   // storage and head data
   always_ff @(posedge clock) begin
      if (write_mem) begin
         mem[wr_ptr_ff] <= wr_data;
      end
      if (head_from_mem) begin
         head_data_ff <= mem[rd_ptr_ff];
      end else if (write_head) begin
         head_data_ff <= wr_data;
      end
   end

   assign head_valid = head_valid_ff;
   assign head_data  = head_data_ff;
   assign level      = LEVEL_W'(count_ff) + LEVEL_W'(head_valid_ff);

endmodule

// ===== hdl/msc_back.sv =====
`timescale 1ns / 1ps

module msc_back #(
   parameter int NUM_STREAMS = msc_pkg::NUM_STREAMS_DEF,
   parameter int ENTRY_W     = 1 + NUM_STREAMS * $bits(msc_pkg::lane_type)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  logic [ENTRY_W-1:0]  head_data,
   output logic                fifo_rd,
   output logic                empty,
   input  logic                pop,
   output msc_pkg::rsp_type    rsp_word
);
   import msc_pkg::*;

   typedef struct packed {
      logic                         data_bit;
      lane_type [NUM_STREAMS-1:0]   lane;
   } entry_type;

   entry_type              entry_ff;
   entry_type              head;
   logic [NUM_STREAMS-1:0] rem_ff;
   logic [NUM_STREAMS-1:0] rem_in;
   logic [NUM_STREAMS-1:0] head_hits;
   logic                   single;
   logic                   done;
   logic                   take;

   assign head = head_data;

   always_comb begin
      for (int s = 0; s < NUM_STREAMS; s++) begin
         head_hits[s] = head.lane[s].hit;
      end
   end

   // streams still owed a result for the current word
   assign single = ((rem_ff & (rem_ff - 1'b1)) == '0);
   assign done   = (rem_ff == '0) || (pop && single);
   assign take   = head_valid && done;
   assign fifo_rd = take;

   always_comb begin
      if (take) begin
         rem_in = head_hits;
      end else if (pop && rem_ff != '0) begin
         rem_in = rem_ff & (rem_ff - 1'b1);
      end else begin
         rem_in = rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         entry_ff <= head;
      end
   end

   // lowest pending stream goes out first
   always_comb begin
      rsp_word             = '0;
      rsp_word.out_bit     = entry_ff.data_bit;
      rsp_word.last_result = single;
      for (int s = NUM_STREAMS - 1; s >= 0; s--) begin
         if (rem_ff[s]) begin
            rsp_word.stream_id  = ID_W'(s);
            rsp_word.stream_pos = entry_ff.lane[s].pos;
            rsp_word.block_end  = entry_ff.lane[s].last;
         end
      end
   end

   assign empty = (rem_ff == '0);

endmodule

// ===== hdl/msc_checker.sv =====
`timescale 1ns / 1ps
`include "msc_stream_demultiplexer_top_defines.svh"

module msc_checker (
   input logic             clock,
   input logic             reset,
   input logic             full,
   input logic             empty,
   input logic             pop,
   input logic             csr_wr_en,
   input msc_pkg::rsp_type rsp_word
);

   logic                      pop_mid;
   logic [msc_pkg::ID_W-1:0]  sid;

   // a non-final result of one bit is being taken
   assign pop_mid = !empty && pop && !rsp_word.last_result;
   assign sid     = rsp_word.stream_id;

   // a waiting result holds until taken
   `MSC_ASSERT_NEXT(a_rsp_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_word))

   // results of one bit come in rising stream order with the last one flagged
   `MSC_ASSERT_NEXT(a_rsp_order, clock, reset, pop_mid, !empty && (sid > $past(sid)))

   // input is held off while the windows recompute after a write
   `MSC_ASSERT_NEXT(a_cfg_hold, clock, reset, csr_wr_en, full)

   // reset leaves no result waiting
   `MSC_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, empty)

endmodule

bind msc_stream_demultiplexer_top msc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .full      (full),
   .empty     (empty),
   .pop       (pop),
   .csr_wr_en (csr_wr_en),
   .rsp_word  (rsp_word)
);

// ===== sim/tb_msc_stream_demultiplexer_top.sv =====
`timescale 1ns / 1ps

module tb_msc_stream_demultiplexer_top;
   import msc_pkg::*;

   localparam int DRAIN_CYCLES     = 16;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int LONG_HOLD        = 300;
   localparam int LONG_FRAME_ITEMS = 8;
   localparam int RANDOM_PHASES    = 8;
   localparam int ITEMS_PER_PHASE  = 44;
   localparam int PAUSE_PHASE      = 4;

   typedef enum logic [1:0] {ROW_WRITE, ROW_PREDICT, ROW_ONE, ROW_NONE} row_kind_type;
   typedef enum logic {RX_STEADY, RX_JITTER} rx_mode_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   index;
      logic [CSR_DATA_W-1:0]  data;
      int                     count;
      req_type                word;
      rsp_type                typed;
   } stim_row_type;

   // part windows of one stream, in bits
   typedef struct packed {
      logic [63:0] off_a;
      logic [63:0] len_a;
      logic [63:0] off_b;
      logic [63:0] len_b;
   } window_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  push      = 1'b0;
   logic                  full;
   req_type               req_word  = '0;
   logic                  empty;
   logic                  pop       = 1'b0;
   rsp_type               rsp_word;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor copy of the registers and the frame position
   logic [16:0] cfg_frame_bits = '0;
   logic [63:0] cfg_part_a     = '0;
   logic [63:0] cfg_part_b     = '0;
   logic [3:0]  cfg_active     = '0;
   logic        cfg_hier       = 1'b0;
   logic [16:0] cfg_hier_bits  = '0;
   logic [16:0] frame_pos      = '0;

   rsp_type      expected_words[$];
   stim_row_type stim_rows[$];
   int           mismatch_count = 0;
   int           rx_hold_left   = 0;
   rx_mode_type  rx_mode        = RX_JITTER;
   bit           tx_jitter      = 1'b1;
   bit           csr_open       = 1'b0;

   msc_stream_demultiplexer_top dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_word  (req_word),
      .empty     (empty),
      .pop       (pop),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // byte length of one stream taken from a packed register, in bits
   function automatic logic [63:0] part_bits(logic [63:0] lens, int s);
      return {48'd0, lens[16*s +: 16]} << 3;
   endfunction

   function automatic window_type stream_window(int s);
      window_type w;
      int t;
      w.off_a = '0;
      w.off_b = '0;
      w.len_a = part_bits(cfg_part_a, s);
      w.len_b = part_bits(cfg_part_b, s);
      // part b follows all active part a data
      for (t = 0; t < 4; t++) begin
         if (cfg_active[t]) w.off_b += part_bits(cfg_part_a, t);
      end
      for (t = 0; t < s; t++) begin
         if (cfg_active[t]) begin
            w.off_a += part_bits(cfg_part_a, t);
            w.off_b += part_bits(cfg_part_b, t);
         end
      end
      // hierarchical frame: stream 0 part b from bit 0, the rest shifted
      if (cfg_hier) begin
         if (s == 0) begin
            w.off_b = '0;
         end else begin
            w.off_a += {47'd0, cfg_hier_bits};
            w.off_b += {47'd0, cfg_hier_bits};
            if (cfg_active[0]) w.off_b -= part_bits(cfg_part_b, 0);
         end
      end
      // a window that does not fit the frame leaves the stream empty
      if (w.off_a + w.len_a > {47'd0, cfg_frame_bits} ||
          w.off_b + w.len_b > {47'd0, cfg_frame_bits}) begin
         w = '0;
      end
      return w;
   endfunction

   // route one bit, queue its words and return how many were queued
   function automatic int demux_bit(req_type w);
      window_type  win;
      logic [63:0] pos;
      logic [63:0] idx;
      rsp_type     word;
      rsp_type     held;
      bit          have_held;
      bit          hit;
      int          n;
      int          s;
      n = 0;
      have_held = 1'b0;
      held = '0;
      if (w.frame_start) frame_pos = '0;
      pos = {47'd0, frame_pos};
      for (s = 0; s < 4; s++) begin
         win = stream_window(s);
         hit = 1'b1;
         idx = '0;
         // part a wins where the two parts of a stream overlap
         if (pos >= win.off_a && pos < win.off_a + win.len_a) begin
            idx = pos - win.off_a;
         end else if (pos >= win.off_b && pos < win.off_b + win.len_b) begin
            idx = win.len_a + (pos - win.off_b);
         end else begin
            hit = 1'b0;
         end
         if (hit) begin
            word.stream_id   = s[1:0];
            word.stream_pos  = idx[16:0];
            word.out_bit     = w.data_bit;
            word.block_end   = (idx + 64'd1 == win.len_a + win.len_b);
            word.last_result = 1'b0;
            if (have_held) expected_words.push_back(held);
            held = word;
            have_held = 1'b1;
            n++;
         end
      end
      if (have_held) begin
         held.last_result = 1'b1;
         expected_words.push_back(held);
      end
      // position saturates instead of wrapping
      if (frame_pos != POS_MAX) frame_pos++;
      return n;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!tx_jitter) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void add_write(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      stim_row_type row;
      row = '{kind: ROW_WRITE, index: index, data: data, count: 0, word: '0, typed: '0};
      stim_rows.push_back(row);
   endfunction

   function automatic void add_bits(row_kind_type kind, int count, logic d, logic fs,
                                    rsp_type typed);
      stim_row_type row;
      row = '{kind: kind, index: '0, data: '0, count: count, word: '0, typed: typed};
      row.word.data_bit    = d;
      row.word.frame_start = fs;
      stim_rows.push_back(row);
   endfunction

   // register write, waiting for the block to go quiet before a group of writes
   task automatic csr_write(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      if (!csr_open) begin
         push <= 1'b0;
         while (expected_words.size() != 0) @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
      end
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_open = 1'b1;
      case (index)
         CSR_FRAME_BITS:      cfg_frame_bits = data[16:0];
         CSR_PART_A_BYTES:    cfg_part_a     = data;
         CSR_PART_B_BYTES:    cfg_part_b     = data;
         CSR_ACTIVE_MASK:     cfg_active     = data[3:0];
         CSR_HIER_MODE:       cfg_hier       = data[0];
         CSR_HIER_FRAME_BITS: cfg_hier_bits  = data[16:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [16:0] frame, logic [63:0] a_bytes, logic [63:0] b_bytes,
                            logic [3:0] active, logic hier, logic [16:0] hier_bits);
      csr_write(CSR_FRAME_BITS, {47'd0, frame});
      csr_write(CSR_PART_A_BYTES, a_bytes);
      csr_write(CSR_PART_B_BYTES, b_bytes);
      csr_write(CSR_ACTIVE_MASK, {60'd0, active});
      csr_write(CSR_HIER_MODE, {63'd0, hier});
      csr_write(CSR_HIER_FRAME_BITS, {47'd0, hier_bits});
   endtask

   // offer one word and record what it should produce once accepted
   task automatic send_bit(req_type w, int gap, row_kind_type kind, rsp_type typed);
      int n;
      if (csr_open) begin
         csr_wr_en <= 1'b0;
         csr_open = 1'b0;
      end
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (full !== 1'b0);
      n = demux_bit(w);
      // typed rows replace the predicted words
      if (kind != ROW_PREDICT) begin
         repeat (n) void'(expected_words.pop_back());
         if (kind == ROW_ONE) expected_words.push_back(typed);
      end
   endtask

   task automatic random_setup();
      logic [15:0] a_len[4];
      logic [15:0] b_len[4];
      logic [3:0]  active;
      logic        hier;
      logic [16:0] hier_bits;
      logic [16:0] frame;
      int          need;
      int          s;
      active    = 4'($urandom_range(0, 15));
      hier      = 1'($urandom_range(0, 1));
      hier_bits = 17'($urandom_range(0, 20));
      need      = hier ? int'(hier_bits) : 0;
      for (s = 0; s < 4; s++) begin
         a_len[s] = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
         b_len[s] = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
         if (active[s]) need += (int'(a_len[s]) + int'(b_len[s])) * 8;
      end
      // mostly a little padding, sometimes a frame too short for the last windows
      if ($urandom_range(0, 3) == 0 && need > 16) need -= int'($urandom_range(1, 16));
      else need += int'($urandom_range(0, 12));
      frame = (need > 400) ? 17'($urandom_range(16, 120)) : 17'(need);
      configure(frame, {a_len[3], a_len[2], a_len[1], a_len[0]},
                {b_len[3], b_len[2], b_len[1], b_len[0]}, active, hier, hier_bits);
   endtask

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_word(rsp_type got);
      rsp_type want;
      if (expected_words.size() == 0) begin
         $error("result word with nothing expected: %h", got);
         mismatch_count++;
      end else begin
         want = expected_words.pop_front();
         compare_field("stream_id", 32'(want.stream_id), 32'(got.stream_id));
         compare_field("stream_pos", 32'(want.stream_pos), 32'(got.stream_pos));
         compare_field("out_bit", 32'(want.out_bit), 32'(got.out_bit));
         compare_field("block_end", 32'(want.block_end), 32'(got.block_end));
         compare_field("last_result", 32'(want.last_result), 32'(got.last_result));
      end
   endtask

   // result side: check each popped word, stall at random or on request
   initial begin
      int r;
      int stall_left;
      stall_left = 0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (pop === 1'b1 && empty === 1'b0) check_word(rsp_word);
         if (rx_hold_left > 0) begin
            rx_hold_left--;
            pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else if (rx_mode == RX_STEADY) begin
            pop <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               pop <= 1'b1;
            end else begin
               if (r >= 96) stall_left = $urandom_range(8, 40);
               pop <= 1'b0;
            end
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   initial begin
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (push === 1'b1 && full === 1'b0) || (pop === 1'b1 && empty === 1'b0))
            idle = 0;
         else
            idle++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      req_type w;
      int      phase;
      int      sent;
      int      i;
      int      frame_len;
      bit      noise;

      do @(posedge clock); while (reset);

      // nothing configured yet: no window anywhere
      add_bits(ROW_NONE, 1, 1'b1, 1'b1, '0);
      // stream 1 part a at the frame start, stream 0 part b behind it
      add_write(CSR_FRAME_BITS, 64'd16);
      add_write(CSR_PART_A_BYTES, 64'h0000_0000_0001_0000);
      add_write(CSR_PART_B_BYTES, 64'h0000_0000_0000_0001);
      add_write(CSR_ACTIVE_MASK, 64'h3);
      add_write(CSR_HIER_MODE, 64'd0);
      add_write(CSR_HIER_FRAME_BITS, 64'd0);
      add_bits(ROW_ONE, 1, 1'b1, 1'b1, rsp_type'({2'd1, 17'd0, 1'b1, 1'b0, 1'b1}));
      add_bits(ROW_PREDICT, 6, 1'b0, 1'b0, '0);
      add_bits(ROW_ONE, 1, 1'b1, 1'b0, rsp_type'({2'd1, 17'd7, 1'b1, 1'b1, 1'b1}));
      add_bits(ROW_ONE, 1, 1'b0, 1'b0, rsp_type'({2'd0, 17'd0, 1'b0, 1'b0, 1'b1}));
      add_bits(ROW_PREDICT, 6, 1'b1, 1'b0, '0);
      add_bits(ROW_ONE, 1, 1'b1, 1'b0, rsp_type'({2'd0, 17'd7, 1'b1, 1'b1, 1'b1}));
      // padding past the frame end
      add_bits(ROW_NONE, 1, 1'b1, 1'b0, '0);
      // hierarchical: stream 0 part b under its part a, stream 1 overlaps it
      add_write(CSR_PART_A_BYTES, 64'h0000_0000_0001_0001);
      add_write(CSR_PART_B_BYTES, 64'h0000_0000_0000_0002);
      add_write(CSR_HIER_MODE, 64'd1);
      add_bits(ROW_ONE, 1, 1'b1, 1'b1, rsp_type'({2'd0, 17'd0, 1'b1, 1'b0, 1'b1}));
      add_bits(ROW_PREDICT, 7, 1'b0, 1'b0, '0);
      add_bits(ROW_PREDICT, 7, 1'b1, 1'b0, '0);
      add_bits(ROW_PREDICT, 1, 1'b0, 1'b0, '0);
      // every register at its top value: all windows impossible
      add_write(CSR_FRAME_BITS, 64'h1_FFFF);
      add_write(CSR_PART_A_BYTES, '1);
      add_write(CSR_PART_B_BYTES, '1);
      add_write(CSR_ACTIVE_MASK, 64'hF);
      add_write(CSR_HIER_FRAME_BITS, 64'h1_FFFF);
      add_bits(ROW_NONE, 1, 1'b1, 1'b1, '0);
      add_bits(ROW_NONE, 1, 1'b0, 1'b0, '0);

      foreach (stim_rows[r]) begin
         if (stim_rows[r].kind == ROW_WRITE) begin
            csr_write(stim_rows[r].index, stim_rows[r].data);
         end else begin
            repeat (stim_rows[r].count)
               send_bit(stim_rows[r].word, pick_gap(), stim_rows[r].kind, stim_rows[r].typed);
         end
      end

      // full-size frame with a wide stream 0 block, only its first bits
      rx_mode   = RX_STEADY;
      tx_jitter = 1'b0;
      configure(17'h1FFFF, 64'h2000, 64'h3FFF, 4'b0001, 1'b1, 17'd0);
      for (i = 0; i < LONG_FRAME_ITEMS; i++) begin
         w.data_bit    = 1'($urandom_range(0, 1));
         w.frame_start = (i == 0);
         send_bit(w, 0, ROW_PREDICT, '0);
      end

      // receiver holds off while a dense frame keeps coming
      configure(17'd64, 64'h0001_0001_0001_0001, 64'h0001_0001_0001_0001, 4'hF, 1'b0, 17'd0);
      rx_hold_left = LONG_HOLD;
      for (i = 0; i < 64; i++) begin
         w.data_bit    = 1'($urandom_range(0, 1));
         w.frame_start = (i == 0);
         send_bit(w, 0, ROW_PREDICT, '0);
      end

      // random settings, mostly whole frames, some broken ones
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         tx_jitter = (phase % 3 != 1);
         rx_mode   = (phase % 3 == 2) ? RX_STEADY : RX_JITTER;
         random_setup();
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            noise = ($urandom_range(0, 99) >= 85);
            if (noise) frame_len = int'($urandom_range(1, int'(cfg_frame_bits) + 12));
            else frame_len = (cfg_frame_bits == 0) ? 1 : int'(cfg_frame_bits);
            for (i = 0; i < frame_len && sent < ITEMS_PER_PHASE; i++) begin
               w.data_bit    = 1'($urandom_range(0, 1));
               w.frame_start = noise ? ($urandom_range(0, 7) == 0) : (i == 0);
               send_bit(w, pick_gap(), ROW_PREDICT, '0);
               sent++;
               // sender waits for every pending word mid-frame
               if (phase == PAUSE_PHASE && sent == ITEMS_PER_PHASE / 2) begin
                  push <= 1'b0;
                  do @(posedge clock); while (expected_words.size() != 0);
               end
            end
         end
      end

      rx_mode = RX_STEADY;
      push <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
